// ----- rtl/bounded_sorted_array_list_defines.svh -----
// assertion macros shared by the rtl
`ifndef BOUNDED_SORTED_ARRAY_LIST_DEFINES_SVH
`define BOUNDED_SORTED_ARRAY_LIST_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BSAL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bsal check failed");

// next-cycle implication, checked out of reset
`define BSAL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bsal check failed");

`endif

// ----- rtl/bsal_pkg.sv -----
package bsal_pkg;

	// list geometry
	localparam int DEPTH        = 64;
	localparam int PAYLOAD_BITS = 64;
	localparam int CNT_W        = $clog2(DEPTH + 1);

	// fixed field widths
	localparam int KEY_W   = 32;
	localparam int PAY_W   = 64;
	localparam int POS_W   = 7;
	localparam int ENTRY_W = 7;

	// operation codes
	typedef enum logic [2:0] {
		FN_APPEND    = 3'd0,
		FN_PREPEND   = 3'd1,
		FN_SORTED    = 3'd2,
		FN_REM_LAST  = 3'd3,
		FN_REM_FIRST = 3'd4,
		FN_REM_KEY   = 3'd5,
		FN_READ      = 3'd6,
		FN_FIND      = 3'd7
	} func_t;

	// controller sequencing
	typedef enum logic {
		ST_IDLE,
		ST_APPLY
	} state_t;

	// what a cell loads on the apply cycle
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD_NEW,
		CELL_FROM_LEFT,
		CELL_FROM_RIGHT
	} cell_act_t;

	typedef struct packed {
		cell_act_t action;
		logic      capture;
	} cell_ctrl_t;

	// one stored record
	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic [PAYLOAD_BITS-1:0] payload;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

	typedef struct packed {
		func_t                   func;
		logic signed [KEY_W-1:0] item_key;
		logic [PAY_W-1:0]        item_payload;
		logic [POS_W-1:0]        position;
	} in_item_t;

	typedef struct packed {
		logic                    ok;
		logic signed [KEY_W-1:0] found_key;
		logic [PAY_W-1:0]        found_payload;
		logic [ENTRY_W-1:0]      entry_count;
		logic                    is_full;
		logic                    is_empty;
	} out_item_t;

	// inclusive prefix or toward higher indexes, log-depth
	function automatic logic [DEPTH-1:0] prefix_or(input logic [DEPTH-1:0] v);
		logic [DEPTH-1:0] r;
		r = v;
		for (int s = 1; s < DEPTH; s = s * 2) begin
			r = r | (r << s);
		end
		return r;
	endfunction

endpackage

// ----- rtl/bsal_cell.sv -----
module bsal_cell (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bsal_pkg::cell_ctrl_t             ctrl,
	input  logic signed [bsal_pkg::KEY_W-1:0] cmp_key,
	input  bsal_pkg::rec_t                   new_rec,
	input  bsal_pkg::rec_t                   left_rec,
	input  bsal_pkg::rec_t                   right_rec,
	output bsal_pkg::rec_t                   rec,
	output logic                             match_s1,
	output logic                             ge_s1
);

	bsal_pkg::rec_t rec_q;

	// record storage, shifted by neighbors
	always_ff @(posedge clk) begin
		unique case (ctrl.action)
			bsal_pkg::CELL_HOLD:       rec_q <= rec_q;
			bsal_pkg::CELL_LOAD_NEW:   rec_q <= new_rec;
			bsal_pkg::CELL_FROM_LEFT:  rec_q <= left_rec;
			bsal_pkg::CELL_FROM_RIGHT: rec_q <= right_rec;
			default:                   rec_q <= rec_q;
		endcase
	end

	// compare flags captured with the incoming transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_s1 <= 1'b0;
			ge_s1    <= 1'b0;
		end else if (ctrl.capture) begin
			match_s1 <= (rec_q.key == cmp_key);
			ge_s1    <= ($signed(rec_q.key) >= cmp_key);
		end
	end

	assign rec = rec_q;

endmodule

// ----- rtl/bounded_sorted_array_list.sv -----
// channel | dir | handshake          | payload
// in      | in  | in_valid/in_ready   | in_data  (func, key, payload, position)
// out     | out | out_valid/out_ready | out_data (ok, found record, count, flags)
//
// for each transaction the accept cycle latches the compare flags in every cell,
// then the apply cycle shifts the cell chain and loads the result register.
// the apply cycle waits while the previous result is still held in the output register.
// reset clears the count and control; record contents are not reset.
// in_ready is low during the apply cycle, so at most one transaction is in flight.
`include "bounded_sorted_array_list_defines.svh"

module bounded_sorted_array_list (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  bsal_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output bsal_pkg::out_item_t out_data
);

	localparam int DEPTH = bsal_pkg::DEPTH;

	bsal_pkg::state_t    state_q, state_nxt;
	logic [bsal_pkg::CNT_W-1:0] count_q, cnt_nxt;
	logic                in_fire, apply_go;
	logic                out_valid_q;
	bsal_pkg::out_item_t out_q, res;
	logic                ok_nxt;

	// transaction captured on accept
	bsal_pkg::func_t                        func_s1;
	logic signed [bsal_pkg::KEY_W-1:0]      key_s1;
	logic [bsal_pkg::PAYLOAD_BITS-1:0]      pay_s1;
	logic [bsal_pkg::POS_W-1:0]             pos_s1;

	bsal_pkg::rec_t       new_rec;
	bsal_pkg::rec_t       cell_rec [DEPTH];
	bsal_pkg::cell_ctrl_t ctrl     [DEPTH];
	bsal_pkg::cell_act_t  act      [DEPTH];
	logic [DEPTH-1:0]     match_w, ge_w;
	logic [DEPTH-1:0]     valid_v, match_v, ge_v, pos_v;
	logic [DEPTH-1:0]     g, incl, excl, first, minc, mfirst, sel;
	logic                 hit, full, empty, ins_op;
	logic [bsal_pkg::REC_W-1:0] found_bits;
	bsal_pkg::rec_t       found_rec;

	assign in_fire  = in_valid && in_ready;
	assign apply_go = (state_q == bsal_pkg::ST_APPLY) && (!out_valid_q || out_ready);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			bsal_pkg::ST_IDLE:  if (in_fire) state_nxt = bsal_pkg::ST_APPLY;
			bsal_pkg::ST_APPLY: if (apply_go) state_nxt = bsal_pkg::ST_IDLE;
			default:            state_nxt = bsal_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		unique case (state_q)
			bsal_pkg::ST_IDLE:  in_ready = 1'b1;
			bsal_pkg::ST_APPLY: in_ready = 1'b0;
			default:            in_ready = 1'b0;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bsal_pkg::ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (apply_go) begin
				count_q     <= cnt_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// transaction and result registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			func_s1 <= in_data.func;
			key_s1  <= in_data.item_key;
			pay_s1  <= in_data.item_payload[bsal_pkg::PAYLOAD_BITS-1:0];
			pos_s1  <= in_data.position;
		end
		if (apply_go) begin
			out_q <= res;
		end
	end

	assign new_rec.key     = key_s1;
	assign new_rec.payload = pay_s1;

	// chain of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		bsal_pkg::rec_t left_rec, right_rec;
		if (i == 0) begin : g_first
			assign left_rec = new_rec;
		end else begin : g_mid_l
			assign left_rec = cell_rec[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_rec = cell_rec[i];
		end else begin : g_mid_r
			assign right_rec = cell_rec[i+1];
		end
		bsal_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl[i]),
			.cmp_key   (in_data.item_key),
			.new_rec   (new_rec),
			.left_rec  (left_rec),
			.right_rec (right_rec),
			.rec       (cell_rec[i]),
			.match_s1  (match_w[i]),
			.ge_s1     (ge_w[i])
		);
	end

	// per-cell occupancy and flags
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			valid_v[i] = 32'(i) < 32'(count_q);
			pos_v[i]   = (32'(pos_s1) == 32'(i + 1)) && valid_v[i];
		end
		match_v = match_w & valid_v;
		ge_v    = ge_w & valid_v;
		full    = (count_q == bsal_pkg::CNT_W'(DEPTH));
		empty   = (count_q == '0);
		hit     = |match_v;
	end

	// insertion or removal point
	always_comb begin
		unique case (func_s1)
			bsal_pkg::FN_APPEND:    g = ~valid_v;
			bsal_pkg::FN_SORTED:    g = ge_v | ~valid_v;
			bsal_pkg::FN_REM_KEY:   g = match_v;
			default:                g = '1;
		endcase
		incl   = bsal_pkg::prefix_or(g);
		excl   = incl << 1;
		first  = g & ~excl;
		minc   = bsal_pkg::prefix_or(match_v);
		mfirst = match_v & ~(minc << 1);
		ins_op = (func_s1 == bsal_pkg::FN_APPEND) || (func_s1 == bsal_pkg::FN_PREPEND)
			|| (func_s1 == bsal_pkg::FN_SORTED);
	end

	// operation decode: cell actions, count and status
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			act[i] = bsal_pkg::CELL_HOLD;
		end
		sel     = '0;
		cnt_nxt = count_q;
		ok_nxt  = 1'b0;
		unique case (func_s1)
			bsal_pkg::FN_APPEND, bsal_pkg::FN_PREPEND, bsal_pkg::FN_SORTED: begin
				if (!full) begin
					ok_nxt  = 1'b1;
					cnt_nxt = count_q + 1'b1;
					for (int i = 0; i < DEPTH; i++) begin
						if (first[i]) act[i] = bsal_pkg::CELL_LOAD_NEW;
						else if (excl[i]) act[i] = bsal_pkg::CELL_FROM_LEFT;
					end
				end
			end
			bsal_pkg::FN_REM_LAST: begin
				if (!empty) begin
					ok_nxt  = 1'b1;
					cnt_nxt = count_q - 1'b1;
				end
			end
			bsal_pkg::FN_REM_FIRST, bsal_pkg::FN_REM_KEY: begin
				if ((func_s1 == bsal_pkg::FN_REM_FIRST) ? !empty : hit) begin
					ok_nxt  = 1'b1;
					cnt_nxt = count_q - 1'b1;
					for (int i = 0; i < DEPTH; i++) begin
						if (incl[i]) act[i] = bsal_pkg::CELL_FROM_RIGHT;
					end
				end
			end
			bsal_pkg::FN_READ: begin
				sel    = pos_v;
				ok_nxt = |pos_v;
			end
			bsal_pkg::FN_FIND: begin
				sel    = mfirst;
				ok_nxt = hit;
			end
			default: ;
		endcase
	end

	// cell controls
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			ctrl[i].action  = apply_go ? act[i] : bsal_pkg::CELL_HOLD;
			ctrl[i].capture = in_fire;
		end
	end

	// one-hot record select and result fields
	always_comb begin
		found_bits = '0;
		for (int i = 0; i < DEPTH; i++) begin
			found_bits = found_bits | ({bsal_pkg::REC_W{sel[i]}} & cell_rec[i]);
		end
		found_rec         = found_bits;
		res.ok            = ok_nxt;
		res.found_key     = found_rec.key;
		res.found_payload = bsal_pkg::PAY_W'(found_rec.payload);
		res.entry_count   = bsal_pkg::ENTRY_W'(cnt_nxt);
		res.is_full       = (cnt_nxt == bsal_pkg::CNT_W'(DEPTH));
		res.is_empty      = (cnt_nxt == '0);
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// checks
	`BSAL_ASSERT_NEXT(a_accept_apply, clk, arst_n, in_fire, state_q == bsal_pkg::ST_APPLY)
	`BSAL_ASSERT_NEXT(a_count_stable, clk, arst_n, !apply_go, $stable(count_q))
	`BSAL_ASSERT_NEXT(a_insert_grows, clk, arst_n, apply_go && ins_op && !full, count_q == $past(count_q) + 1'b1)
	`BSAL_ASSERT_NOW(a_sel_onehot, clk, arst_n, state_q == bsal_pkg::ST_APPLY, $onehot0(sel))

endmodule
